[src/wsdf_pkg.sv]
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

	localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd8388608;

	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	localparam logic [2:0] EXT_COUNT_16 = 3'd1;
	localparam logic [2:0] EXT_COUNT_64 = 3'd7;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_TEXT      = 2'd0,
		KIND_PING      = 2'd1,
		KIND_CLOSE     = 2'd2,
		KIND_VIOLATION = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] key;
		logic       last;
		logic       empty;
	} token_t;

endpackage

[src/wsdf_front.sv]
// ----------------------------------------------------------------------------
// wsdf_front
// Header parser: tracks the frame phase per received byte and issues one
// token for each byte that yields a result.
// ----------------------------------------------------------------------------
module wsdf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       rx_byte,
	output logic             tok_valid,
	output wsdf_pkg::token_t tok,
	input  logic             tok_ready
);

	wsdf_pkg::phase_t phase_q, phase_d;
	logic [2:0]  ext_cnt_q, ext_cnt_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_q, mask_d;
	logic [31:0] key_q, key_d;
	logic [63:0] rem_q, rem_d;
	logic [1:0]  kidx_q, kidx_d;
	logic        halted_q, halted_d;
	logic [31:0] max_q;
	logic        emit;
	logic        do_len;
	logic        do_begin;
	logic        in_fire;
	logic [7:0]  key_byte;

	assign in_ready  = halted_q | tok_ready;
	assign in_fire   = in_valid & in_ready;
	assign tok_valid = in_fire & emit;

	always_comb begin
		case (kidx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		ext_cnt_d = ext_cnt_q;
		opcode_d  = opcode_q;
		mask_d    = mask_q;
		key_d     = key_q;
		rem_d     = rem_q;
		kidx_d    = kidx_q;
		halted_d  = halted_q;
		emit      = 1'b0;
		do_len    = 1'b0;
		do_begin  = 1'b0;
		tok.kind  = wsdf_pkg::KIND_VIOLATION;
		tok.data  = 8'd0;
		tok.key   = 8'd0;
		tok.last  = 1'b1;
		tok.empty = 1'b0;
		if (!halted_q) begin
			unique case (phase_q)
				wsdf_pkg::PH_HDR1: begin
					mask_d = rx_byte[7];
					rem_d  = 64'd0;
					if (rx_byte[6:0] == wsdf_pkg::LEN_CODE_16) begin
						ext_cnt_d = wsdf_pkg::EXT_COUNT_16;
						phase_d   = wsdf_pkg::PH_EXTLEN;
					end else if (rx_byte[6:0] == wsdf_pkg::LEN_CODE_64) begin
						ext_cnt_d = wsdf_pkg::EXT_COUNT_64;
						phase_d   = wsdf_pkg::PH_EXTLEN;
					end else begin
						rem_d  = {57'd0, rx_byte[6:0]};
						do_len = 1'b1;
					end
				end
				wsdf_pkg::PH_EXTLEN: begin
					rem_d = {rem_q[55:0], rx_byte};
					if (ext_cnt_q != 3'd0) begin
						ext_cnt_d = ext_cnt_q - 3'd1;
					end else begin
						do_len = 1'b1;
					end
				end
				wsdf_pkg::PH_MASK: begin
					key_d = {key_q[23:0], rx_byte};
					if (kidx_q != 2'd3) begin
						kidx_d = kidx_q + 2'd1;
					end else begin
						do_begin = 1'b1;
					end
				end
				wsdf_pkg::PH_PAYLOAD: begin
					kidx_d   = kidx_q + 2'd1;
					rem_d    = rem_q - 64'd1;
					tok.data = rx_byte;
					tok.key  = mask_q ? key_byte : 8'd0;
					tok.last = (rem_q == 64'd1);
					if (rem_q == 64'd1) begin
						phase_d = wsdf_pkg::PH_HDR0;
					end
					if (opcode_q == wsdf_pkg::OP_TEXT) begin
						emit     = 1'b1;
						tok.kind = wsdf_pkg::KIND_TEXT;
					end else if (opcode_q == wsdf_pkg::OP_PING) begin
						emit     = 1'b1;
						tok.kind = wsdf_pkg::KIND_PING;
					end else if (opcode_q == wsdf_pkg::OP_CLOSE && rem_q == 64'd1) begin
						emit     = 1'b1;
						halted_d = 1'b1;
						tok.kind = wsdf_pkg::KIND_CLOSE;
						tok.data = 8'd0;
						tok.key  = 8'd0;
					end
				end
				default: begin
					if (!rx_byte[7]) begin
						emit     = 1'b1;
						halted_d = 1'b1;
						phase_d  = wsdf_pkg::PH_HDR0;
					end else begin
						opcode_d = rx_byte[3:0];
						phase_d  = wsdf_pkg::PH_HDR1;
					end
				end
			endcase

			if (do_len) begin
				if (rem_d > {32'd0, max_q}) begin
					emit     = 1'b1;
					halted_d = 1'b1;
					phase_d  = wsdf_pkg::PH_HDR0;
					tok.kind = wsdf_pkg::KIND_VIOLATION;
				end else if (mask_d) begin
					kidx_d  = 2'd0;
					phase_d = wsdf_pkg::PH_MASK;
				end else begin
					do_begin = 1'b1;
				end
			end

			if (do_begin) begin
				kidx_d = 2'd0;
				if (rem_d != 64'd0) begin
					phase_d = wsdf_pkg::PH_PAYLOAD;
				end else begin
					phase_d   = wsdf_pkg::PH_HDR0;
					tok.empty = 1'b1;
					if (opcode_q == wsdf_pkg::OP_TEXT) begin
						emit     = 1'b1;
						tok.kind = wsdf_pkg::KIND_TEXT;
					end else if (opcode_q == wsdf_pkg::OP_PING) begin
						emit     = 1'b1;
						tok.kind = wsdf_pkg::KIND_PING;
					end else if (opcode_q == wsdf_pkg::OP_CLOSE) begin
						emit      = 1'b1;
						halted_d  = 1'b1;
						tok.kind  = wsdf_pkg::KIND_CLOSE;
						tok.empty = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= wsdf_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= wsdf_pkg::PH_HDR0;
			ext_cnt_q <= 3'd0;
			opcode_q  <= 4'd0;
			mask_q    <= 1'b0;
			key_q     <= 32'd0;
			rem_q     <= 64'd0;
			kidx_q    <= 2'd0;
			halted_q  <= 1'b0;
		end else if (in_fire) begin
			phase_q   <= phase_d;
			ext_cnt_q <= ext_cnt_d;
			opcode_q  <= opcode_d;
			mask_q    <= mask_d;
			key_q     <= key_d;
			rem_q     <= rem_d;
			kidx_q    <= kidx_d;
			halted_q  <= halted_d;
		end
	end

endmodule

[src/wsdf_queue.sv]
// ----------------------------------------------------------------------------
// wsdf_queue
// Two-entry token queue between the header parser and the output stage.
// ----------------------------------------------------------------------------
module wsdf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wsdf_pkg::token_t push_tok,
	output logic             not_full,
	output logic             not_empty,
	input  logic             pop,
	output wsdf_pkg::token_t pop_tok
);

	wsdf_pkg::token_t entry_q [wsdf_pkg::QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign not_full  = (count_q != 2'(wsdf_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != 2'd0);
	assign pop_tok   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/wsdf_back.sv]
// ----------------------------------------------------------------------------
// wsdf_back
// Output stage: unmasks the queued payload byte and holds the result until
// the transfer completes.
// ----------------------------------------------------------------------------
module wsdf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_valid,
	input  wsdf_pkg::token_t tok,
	output logic             tok_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       data_byte,
	output logic             last_of_frame,
	output logic             empty_frame
);

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       empty_q;

	assign tok_pop       = tok_valid & (~valid_q | out_ready);
	assign out_valid     = valid_q;
	assign kind          = kind_q;
	assign data_byte     = data_q;
	assign last_of_frame = last_q;
	assign empty_frame   = empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (~valid_q | out_ready) begin
			valid_q <= tok_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop) begin
			kind_q  <= tok.kind;
			data_q  <= tok.data ^ tok.key;
			last_q  <= tok.last;
			empty_q <= tok.empty;
		end
	end

endmodule

[src/websocket_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// WebSocket receive-side frame parser with payload unmasking.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  config   | cfg_we                   | cfg_wdata (max_payload_bytes)
//  input    | in_valid / in_ready      | rx_byte
//  output   | out_valid / out_ready    | kind, data_byte, last_of_frame,
//           |                          | empty_frame
//
//  One byte per cycle while in_ready is high; results are registered.
//  The parser feeds a two-entry queue that the output register drains.
//  in_ready drops only while the queue is full; after a halt every byte is
//  taken and dropped. Reset restores all parse state and the length limit.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic        last_of_frame,
	output logic        empty_frame
);

	wsdf_pkg::token_t front_tok;
	wsdf_pkg::token_t queue_tok;
	logic             front_valid;
	logic             queue_not_full;
	logic             queue_not_empty;
	logic             queue_pop;

	wsdf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.tok_valid (front_valid),
		.tok       (front_tok),
		.tok_ready (queue_not_full)
	);

	wsdf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_tok  (front_tok),
		.not_full  (queue_not_full),
		.not_empty (queue_not_empty),
		.pop       (queue_pop),
		.pop_tok   (queue_tok)
	);

	wsdf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_valid     (queue_not_empty),
		.tok           (queue_tok),
		.tok_pop       (queue_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.data_byte     (data_byte),
		.last_of_frame (last_of_frame),
		.empty_frame   (empty_frame)
	);

endmodule
